// ===== src/crc8_checked_sensor_frame_decoder_top_assert.svh =====
// Assertion macros shared by the frame decoder modules
`ifndef CRC8_CHECKED_SENSOR_FRAME_DECODER_TOP_ASSERT_SVH
`define CRC8_CHECKED_SENSOR_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define CSFD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/csfd_pkg.sv =====
// Shared types, constants and functions of the sensor frame decoder
`default_nettype none
package csfd_pkg;

   localparam logic [7:0]  CRC_POLY = 8'h31;
   localparam logic [7:0]  CRC_INIT = 8'hFF;
   localparam logic [2:0]  POS_CHECK_FIRST = 3'd2;
   localparam logic [2:0]  POS_CHECK_SECOND = 3'd5;
   localparam logic [2:0]  POS_AFTER_FIRST = 3'd3;
   localparam logic [2:0]  LAST_POS_MEAS = 3'd5;
   localparam logic [2:0]  LAST_POS_STATUS = 3'd2;
   localparam logic        MODE_MEAS = 1'b0;
   localparam logic        MODE_STATUS = 1'b1;
   localparam logic [14:0] TEMP_SPAN = 15'd17500;
   localparam logic [13:0] HUM_SPAN = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [16:0] RAW_FULL = 17'd65535;
   localparam int          QUEUE_DEPTH = 4;
   localparam int          QPTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [15:0] first_word;
      logic [15:0] second_word;
      logic        crc_ok;
      logic        scale;
   } frame_rec_type;

   function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // floor(x / 65535) for x below 2^31
   function automatic logic [15:0] div_full(input logic [30:0] x);
      logic [14:0] q0;
      logic [16:0] r;
      q0 = x[30:16];
      r = {1'b0, x[15:0]} + {2'b00, q0};
      return {1'b0, q0} + ((r >= RAW_FULL) ? 16'd1 : 16'd0);
   endfunction

endpackage
`default_nettype wire

// ===== src/csfd_front.sv =====
// Byte intake: word assembly, CRC check and frame classification
`default_nettype none
module csfd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_valid,
   input  wire logic [7:0]             byte_data,
   input  wire logic                   csr_write,
   input  wire logic                   csr_mode,
   output csfd_pkg::frame_rec_type     rec,
   output logic                        rec_push
);

`include "crc8_checked_sensor_frame_decoder_top_assert.svh"

   logic        mode_ff, mode_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] word_ff, word_in;
   logic [15:0] held_ff, held_in;
   logic        fok_ff, fok_in;

   logic [2:0]  last_pos;
   logic        stray;
   logic [2:0]  pos_cur;
   logic [7:0]  crc_cur;
   logic [15:0] word_cur;
   logic        ok;

   always_comb begin
      last_pos = (mode_ff == csfd_pkg::MODE_STATUS) ? csfd_pkg::LAST_POS_STATUS
                                                    : csfd_pkg::LAST_POS_MEAS;
      stray    = pos_ff > last_pos;
      pos_cur  = stray ? 3'd0 : pos_ff;
      crc_cur  = stray ? csfd_pkg::CRC_INIT : crc_ff;
      word_cur = stray ? 16'd0 : word_ff;
      ok       = (crc_cur == byte_data);

      mode_in  = mode_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      word_in  = word_ff;
      held_in  = held_ff;
      fok_in   = fok_ff;
      rec_push = 1'b0;
      rec.first_word  = (mode_ff == csfd_pkg::MODE_STATUS) ? word_cur : held_ff;
      rec.second_word = (mode_ff == csfd_pkg::MODE_STATUS) ? 16'd0 : word_cur;
      rec.crc_ok      = (mode_ff == csfd_pkg::MODE_STATUS) ? ok : (ok && fok_ff);
      rec.scale       = (mode_ff == csfd_pkg::MODE_MEAS) && ok && fok_ff;

      priority if (csr_write) begin
         mode_in = csr_mode;
         pos_in  = 3'd0;
         crc_in  = csfd_pkg::CRC_INIT;
         word_in = 16'd0;
      end else if (byte_valid) begin
         if (pos_cur != csfd_pkg::POS_CHECK_FIRST && pos_cur != csfd_pkg::POS_CHECK_SECOND) begin
            crc_in  = csfd_pkg::crc_next(crc_cur, byte_data);
            word_in = {word_cur[7:0], byte_data};
            pos_in  = pos_cur + 3'd1;
         end else if (pos_cur == csfd_pkg::POS_CHECK_FIRST
                      && mode_ff == csfd_pkg::MODE_MEAS) begin
            held_in = word_cur;
            fok_in  = ok;
            crc_in  = csfd_pkg::CRC_INIT;
            word_in = 16'd0;
            pos_in  = csfd_pkg::POS_AFTER_FIRST;
         end else begin
            rec_push = 1'b1;
            crc_in   = csfd_pkg::CRC_INIT;
            word_in  = 16'd0;
            pos_in   = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= csfd_pkg::MODE_MEAS;
         pos_ff  <= 3'd0;
         crc_ff  <= csfd_pkg::CRC_INIT;
         word_ff <= 16'd0;
         held_ff <= 16'd0;
         fok_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         word_ff <= word_in;
         held_ff <= held_in;
         fok_ff  <= fok_in;
      end
   end

   `CSFD_ASSERT_IMPL(a_status_pos, clock, reset, mode_ff == csfd_pkg::MODE_STATUS, pos_ff <= csfd_pkg::LAST_POS_STATUS)

endmodule
`default_nettype wire

// ===== src/csfd_queue.sv =====
// Short queue of frame records between intake and scaling
`default_nettype none
module csfd_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  csfd_pkg::frame_rec_type     push_rec,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        valid,
   output csfd_pkg::frame_rec_type     head
);

`include "crc8_checked_sensor_frame_decoder_top_assert.svh"

   localparam logic [csfd_pkg::QPTR_W:0] DEPTH = (csfd_pkg::QPTR_W + 1)'(csfd_pkg::QUEUE_DEPTH);

   csfd_pkg::frame_rec_type mem_ff [csfd_pkg::QUEUE_DEPTH];
   logic [csfd_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [csfd_pkg::QPTR_W:0]   cnt_ff, cnt_in;
   logic do_push, do_pop;

   always_comb begin
      full    = (cnt_ff == DEPTH);
      valid   = (cnt_ff != '0);
      head    = mem_ff[rd_ff];
      do_push = push && !full;
      do_pop  = pop && valid;
      wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in  = cnt_ff + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `CSFD_ASSERT_IMPL(a_no_overflow, clock, reset, push, !full)
   `CSFD_ASSERT_NEXT(a_cnt_grow, clock, reset, push && !pop && !full, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule
`default_nettype wire

// ===== src/csfd_back.sv =====
// Scaling pipeline: constant multiply, divide by full scale, output register
`default_nettype none
module csfd_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_valid,
   input  csfd_pkg::frame_rec_type     q_head,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [63:0]                 rsp_tdata
);

`include "crc8_checked_sensor_frame_decoder_top_assert.svh"

   logic                    s1_valid_ff, s1_valid_in;
   csfd_pkg::frame_rec_type s1_rec_ff;
   logic [30:0]             s1_tprod_ff;
   logic [29:0]             s1_hprod_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [15:0]             out_w1_ff, out_w2_ff;
   logic [14:0]             out_temp_ff, out_temp_in;
   logic [13:0]             out_hum_ff, out_hum_in;
   logic                    out_ok_ff;
   logic                    out_go, s1_go;
   logic [15:0]             tq, hq, tdiff;

   always_comb begin
      out_go       = !out_valid_ff || rsp_tready;
      s1_go        = !s1_valid_ff || out_go;
      q_pop        = q_valid && s1_go;
      s1_valid_in  = s1_go ? q_valid : s1_valid_ff;
      out_valid_in = out_go ? s1_valid_ff : out_valid_ff;
      tq           = csfd_pkg::div_full(s1_tprod_ff);
      hq           = csfd_pkg::div_full({1'b0, s1_hprod_ff});
      tdiff        = tq - csfd_pkg::TEMP_OFFSET;
      out_temp_in  = s1_rec_ff.scale ? tdiff[14:0] : 15'd0;
      out_hum_in   = s1_rec_ff.scale ? hq[13:0] : 14'd0;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_rec_ff   <= q_head;
         s1_tprod_ff <= 31'(csfd_pkg::TEMP_SPAN * q_head.first_word);
         s1_hprod_ff <= 30'(csfd_pkg::HUM_SPAN * q_head.second_word);
      end
      if (out_go && s1_valid_ff) begin
         out_w1_ff   <= s1_rec_ff.first_word;
         out_w2_ff   <= s1_rec_ff.second_word;
         out_temp_ff <= out_temp_in;
         out_hum_ff  <= out_hum_in;
         out_ok_ff   <= s1_rec_ff.crc_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ok_ff, out_hum_ff, out_temp_ff, out_w2_ff, out_w1_ff};

   `CSFD_ASSERT_IMPL(a_zero_on_fail, clock, reset, out_valid_ff && !out_ok_ff, out_temp_ff == 15'd0 && out_hum_ff == 14'd0)

endmodule
`default_nettype wire

// ===== src/crc8_checked_sensor_frame_decoder_top.sv =====
// Top level of the CRC-8 checked sensor frame decoder
// Takes one sensor byte per transaction and may accept a byte every clock
// cycle; req_tready drops while the four-entry record queue is full and while
// a csr write is offered.
// Each 16-bit word is checked against its CRC-8 byte (poly 0x31, init 0xFF)
// as the byte arrives. A frame (six bytes in measurement mode, three in status
// mode) yields one result on rsp: the edge that takes its last byte writes the
// queue, a later edge registers the constant multiply into s1, and then the
// divide by 65535 goes into the output register; either step can stall.
// A write on csr selects the frame mode and restarts the frame;
// write it only while no frame is in progress.
`default_nettype none
module crc8_checked_sensor_frame_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [15:0] first_word, [31:16] second_word,
                                         // [46:32] temperature_centi, [60:47] humidity_centi,
                                         // [61] crc_ok, [63:62] zero
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data     // [0] frame_mode
);

   csfd_pkg::frame_rec_type push_rec, head;
   logic push, full, pop, q_valid;

   assign req_tready = !full && !csr_valid;
   assign csr_ready  = 1'b1;

   csfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid && req_tready),
      .byte_data  (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_mode   (csr_data),
      .rec        (push_rec),
      .rec_push   (push)
   );

   csfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (full),
      .pop      (pop),
      .valid    (q_valid),
      .head     (head)
   );

   csfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (head),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
